// File: hdl/flrs_pkg.sv
// Shared codes and types for the fan and light relay sequencer.
`timescale 1ns / 1ps
`default_nettype none

package flrs_pkg;

  // Command codes carried in a command beat.
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_FAN_ON    = 3'd1;
  localparam logic [2:0] CMD_FAN_OFF   = 3'd2;
  localparam logic [2:0] CMD_WHITE_ON  = 3'd3;
  localparam logic [2:0] CMD_WHITE_OFF = 3'd4;
  localparam logic [2:0] CMD_VYV_ON    = 3'd5;
  localparam logic [2:0] CMD_VYV_OFF   = 3'd6;

  // Light modes.
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_WHITE = 2'd1;
  localparam logic [1:0] MODE_VYV   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_WHITE_PULSE = 2'd0;
  localparam logic [1:0] REG_VYV_PULSE   = 2'd1;
  localparam logic [1:0] REG_VYV_TIMEOUT = 2'd2;

  localparam logic [15:0] WHITE_PULSE_RST = 16'd500;
  localparam logic [15:0] VYV_PULSE_RST   = 16'd500;
  localparam logic [23:0] VYV_TIMEOUT_RST = 24'd2000;

  // One result beat.
  typedef struct packed {
    logic       fan_on_req;
    logic       fan_off_req;
    logic       light_on_req;
    logic       light_off_req;
    logic       busy_res;
    logic [1:0] light_mode;
    logic [1:0] mode_memory;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/fan_light_relay_sequencer.sv
// Top level of the fan and light relay sequencer.
//
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_stall    cmd_write, cmd, ms_tick, relay busy, relay status
//  out_     output     out_valid / out_stall  four pulse requests, busy_res, light modes
//  cfg_     input      cfg_valid / cfg_ready  cfg_addr (register index), cfg_data
//
// Each step beat is captured in an input register and from there runs one transition of
// the sequencer into the result register; a new beat can be taken every clock while the
// result is not stalled. Reset (rst_n low, synchronous) puts the sequencer idle with mode
// VYV and the timers at zero. A stalled result holds the result register; the input
// register then fills and in_stall rises until the result is taken. Configuration writes
// are taken in any cycle.
`timescale 1ns / 1ps
`default_nettype none

module fan_light_relay_sequencer (
  input  wire         clk,
  input  wire         rst_n,

  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_cmd_write,
  input  wire  [2:0]  in_cmd,
  input  wire         in_ms_tick,
  input  wire         in_fan_on_busy,
  input  wire         in_fan_off_busy,
  input  wire         in_light_on_busy,
  input  wire         in_light_off_busy,
  input  wire         in_light_relay_on,

  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_fan_on_req,
  output logic        out_fan_off_req,
  output logic        out_light_on_req,
  output logic        out_light_off_req,
  output logic        out_busy_res,
  output logic [1:0]  out_light_mode,
  output logic [1:0]  out_mode_memory,

  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_addr,
  input  wire  [23:0] cfg_data
);

  localparam logic [4:0] PH_IDLE         = 5'd0;
  localparam logic [4:0] PH_FAN_ON       = 5'd1;
  localparam logic [4:0] PH_FAN_ON_WAIT  = 5'd2;
  localparam logic [4:0] PH_FAN_OFF      = 5'd3;
  localparam logic [4:0] PH_FAN_OFF_WAIT = 5'd4;
  localparam logic [4:0] PH_SEL_WHITE    = 5'd5;
  localparam logic [4:0] PH_SEL_VYV      = 5'd6;
  localparam logic [4:0] PH_PULSE_ON     = 5'd7;
  localparam logic [4:0] PH_PULSE_OFF    = 5'd8;
  localparam logic [4:0] PH_PULSE_WAIT   = 5'd9;
  localparam logic [4:0] PH_LOFF         = 5'd10;
  localparam logic [4:0] PH_LOFF_WAIT    = 5'd11;
  localparam logic [4:0] PH_LOFF_DONE    = 5'd12;

  // Configuration registers.
  logic [15:0] white_pulse_r;
  logic [15:0] vyv_pulse_r;
  logic [23:0] vyv_timeout_r;

  // Input register.
  logic        in_full_r;
  logic        cmd_write_r;
  logic [2:0]  cmd_r;
  logic        ms_tick_r;
  logic        fan_on_busy_r;
  logic        fan_off_busy_r;
  logic        light_on_busy_r;
  logic        light_off_busy_r;
  logic        relay_on_r;

  // Sequencer state.
  logic [4:0]  phase_r, phase_nxt;
  logic [2:0]  pending_r, pending_nxt;
  logic        busy_r, busy_nxt;
  logic [1:0]  mode_now_r, mode_now_nxt;
  logic [1:0]  mode_next_r, mode_next_nxt;
  logic        target_r, target_nxt;
  logic [1:0]  index_r, index_nxt;
  logic        use_vyv_r, use_vyv_nxt;
  logic [15:0] pulse_el_r, pulse_el_nxt;
  logic [23:0] tmo_el_r, tmo_el_nxt;

  // Result register.
  logic                  out_full_r;
  flrs_pkg::result_t     res_r, res_nxt;

  logic        in_accept;
  logic        step;
  logic        start_ok;
  logic [4:0]  start_phase;
  logic [2:0]  pend_in;
  logic [15:0] pulse_tick;
  logic [23:0] tmo_tick;
  logic [15:0] deadline;
  logic        want_vyv;

  assign step      = in_full_r && (!out_full_r || !out_stall);
  assign in_stall  = in_full_r && !step;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_pulse_r <= flrs_pkg::WHITE_PULSE_RST;
      vyv_pulse_r   <= flrs_pkg::VYV_PULSE_RST;
      vyv_timeout_r <= flrs_pkg::VYV_TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_addr)
        flrs_pkg::REG_WHITE_PULSE: white_pulse_r <= cfg_data[15:0];
        flrs_pkg::REG_VYV_PULSE:   vyv_pulse_r   <= cfg_data[15:0];
        flrs_pkg::REG_VYV_TIMEOUT: vyv_timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_accept) begin
      in_full_r <= 1'b1;
    end else if (step) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_write_r      <= in_cmd_write;
      cmd_r            <= in_cmd;
      ms_tick_r        <= in_ms_tick;
      fan_on_busy_r    <= in_fan_on_busy;
      fan_off_busy_r   <= in_fan_off_busy;
      light_on_busy_r  <= in_light_on_busy;
      light_off_busy_r <= in_light_off_busy;
      relay_on_r       <= in_light_relay_on;
    end
  end

  // Command decode, against the pending command after this beat's write.
  always_comb begin
    pend_in     = cmd_write_r ? cmd_r : pending_r;
    start_phase = PH_IDLE;
    start_ok    = 1'b0;
    case (pend_in)
      flrs_pkg::CMD_FAN_ON:    begin start_phase = PH_FAN_ON;    start_ok = 1'b1; end
      flrs_pkg::CMD_FAN_OFF:   begin start_phase = PH_FAN_OFF;   start_ok = 1'b1; end
      flrs_pkg::CMD_WHITE_ON:  begin start_phase = PH_SEL_WHITE; start_ok = 1'b1; end
      flrs_pkg::CMD_WHITE_OFF: begin start_phase = PH_LOFF;      start_ok = 1'b1; end
      flrs_pkg::CMD_VYV_ON:    begin start_phase = PH_SEL_VYV;   start_ok = 1'b1; end
      flrs_pkg::CMD_VYV_OFF:   begin start_phase = PH_LOFF;      start_ok = 1'b1; end
      default: ;
    endcase
    start_ok = start_ok && !busy_r;
  end

  always_comb begin
    pulse_tick = (ms_tick_r && pulse_el_r != 16'hFFFF) ? pulse_el_r + 16'd1 : pulse_el_r;
    tmo_tick   = (ms_tick_r && tmo_el_r != 24'hFFFFFF) ? tmo_el_r + 24'd1 : tmo_el_r;
    deadline   = use_vyv_r ? vyv_pulse_r : white_pulse_r;
    want_vyv   = (phase_r == PH_SEL_VYV);

    phase_nxt     = phase_r;
    pending_nxt   = pend_in;
    busy_nxt      = busy_r;
    mode_now_nxt  = mode_now_r;
    mode_next_nxt = mode_next_r;
    target_nxt    = target_r;
    index_nxt     = index_r;
    use_vyv_nxt   = use_vyv_r;
    pulse_el_nxt  = pulse_tick;
    tmo_el_nxt    = tmo_tick;
    res_nxt       = '0;

    case (phase_r)
      PH_IDLE: begin
        if (start_ok) begin
          phase_nxt   = start_phase;
          busy_nxt    = 1'b1;
          pending_nxt = flrs_pkg::CMD_NONE;
        end
      end
      PH_FAN_ON: begin
        res_nxt.fan_on_req = 1'b1;
        phase_nxt = PH_FAN_ON_WAIT;
      end
      PH_FAN_ON_WAIT: begin
        if (!fan_on_busy_r) begin
          busy_nxt  = 1'b0;
          phase_nxt = PH_IDLE;
        end
      end
      PH_FAN_OFF: begin
        res_nxt.fan_off_req = 1'b1;
        phase_nxt = PH_FAN_OFF_WAIT;
      end
      PH_FAN_OFF_WAIT: begin
        if (!fan_off_busy_r) begin
          busy_nxt  = 1'b0;
          phase_nxt = PH_IDLE;
        end
      end
      PH_SEL_WHITE, PH_SEL_VYV: begin
        use_vyv_nxt = want_vyv;
        index_nxt   = 2'd0;
        // The number of extra toggles depends on where the relay's own mode memory sits.
        if (mode_now_r == flrs_pkg::MODE_WHITE) begin
          target_nxt = !want_vyv;
          phase_nxt  = PH_PULSE_OFF;
        end else if (mode_now_r == flrs_pkg::MODE_VYV) begin
          target_nxt = want_vyv;
          phase_nxt  = PH_PULSE_OFF;
        end else begin
          if (mode_next_r == flrs_pkg::MODE_VYV) begin
            target_nxt = !want_vyv;
          end else if (mode_next_r == flrs_pkg::MODE_WHITE) begin
            target_nxt = want_vyv;
          end
          phase_nxt = PH_PULSE_ON;
        end
        mode_now_nxt  = want_vyv ? flrs_pkg::MODE_VYV : flrs_pkg::MODE_WHITE;
        mode_next_nxt = flrs_pkg::MODE_OFF;
      end
      PH_PULSE_ON: begin
        res_nxt.light_on_req = 1'b1;
        pulse_el_nxt = '0;
        phase_nxt    = PH_PULSE_WAIT;
      end
      PH_PULSE_OFF: begin
        res_nxt.light_off_req = 1'b1;
        pulse_el_nxt = '0;
        phase_nxt    = PH_PULSE_WAIT;
      end
      PH_PULSE_WAIT: begin
        if (pulse_tick >= deadline) begin
          if (relay_on_r) begin
            if (!light_on_busy_r) begin
              if (index_r >= {1'b0, target_r}) begin
                busy_nxt  = 1'b0;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_PULSE_OFF;
              end
              index_nxt = index_r + 2'd1;
            end
          end else if (!light_off_busy_r) begin
            phase_nxt = PH_PULSE_ON;
          end
        end
      end
      PH_LOFF: begin
        res_nxt.light_off_req = 1'b1;
        phase_nxt = PH_LOFF_WAIT;
      end
      PH_LOFF_WAIT: begin
        if (!light_off_busy_r) begin
          tmo_el_nxt = '0;
          busy_nxt   = 1'b0;
          phase_nxt  = PH_LOFF_DONE;
        end
      end
      PH_LOFF_DONE: begin
        if (mode_now_r == flrs_pkg::MODE_VYV) begin
          mode_now_nxt  = flrs_pkg::MODE_OFF;
          mode_next_nxt = flrs_pkg::MODE_WHITE;
          phase_nxt     = PH_IDLE;
          busy_nxt      = 1'b0;
        end else if (mode_now_r == flrs_pkg::MODE_WHITE) begin
          mode_now_nxt  = flrs_pkg::MODE_OFF;
          mode_next_nxt = flrs_pkg::MODE_VYV;
          busy_nxt      = 1'b0;
        end else begin
          if (start_ok) begin
            phase_nxt   = start_phase;
            busy_nxt    = 1'b1;
            pending_nxt = flrs_pkg::CMD_NONE;
          end
          if (mode_next_r == flrs_pkg::MODE_VYV) begin
            // The VYV memory lapses back to white once the re-arm window has passed.
            if (tmo_tick >= vyv_timeout_r && !start_ok && !busy_r) begin
              mode_now_nxt  = flrs_pkg::MODE_OFF;
              mode_next_nxt = flrs_pkg::MODE_WHITE;
              phase_nxt     = PH_IDLE;
              busy_nxt      = 1'b0;
            end
          end else begin
            // Unless VYV is remembered, a command taken here is dropped.
            busy_nxt  = 1'b0;
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    res_nxt.busy_res    = busy_nxt;
    res_nxt.light_mode  = mode_now_nxt;
    res_nxt.mode_memory = mode_next_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pending_r   <= flrs_pkg::CMD_NONE;
      busy_r      <= 1'b0;
      mode_now_r  <= flrs_pkg::MODE_VYV;
      mode_next_r <= flrs_pkg::MODE_OFF;
      target_r    <= 1'b0;
      index_r     <= 2'd0;
      use_vyv_r   <= 1'b0;
      pulse_el_r  <= '0;
      tmo_el_r    <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      pending_r   <= pending_nxt;
      busy_r      <= busy_nxt;
      mode_now_r  <= mode_now_nxt;
      mode_next_r <= mode_next_nxt;
      target_r    <= target_nxt;
      index_r     <= index_nxt;
      use_vyv_r   <= use_vyv_nxt;
      pulse_el_r  <= pulse_el_nxt;
      tmo_el_r    <= tmo_el_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_full_r <= 1'b0;
    end else if (step) begin
      out_full_r <= 1'b1;
    end else if (!out_stall) begin
      out_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_full_r;
  assign out_fan_on_req    = res_r.fan_on_req;
  assign out_fan_off_req   = res_r.fan_off_req;
  assign out_light_on_req  = res_r.light_on_req;
  assign out_light_off_req = res_r.light_off_req;
  assign out_busy_res      = res_r.busy_res;
  assign out_light_mode    = res_r.light_mode;
  assign out_mode_memory   = res_r.mode_memory;

  // A result beat never asks for more than one relay pulse.
  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_full_r |-> $onehot0({res_r.fan_on_req, res_r.fan_off_req,
                             res_r.light_on_req, res_r.light_off_req}))
    else $error("more than one pulse request in a result beat");

  // Every pulse request belongs to a command in progress.
  a_pulse_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_full_r && (res_r.fan_on_req || res_r.fan_off_req ||
                    res_r.light_on_req || res_r.light_off_req)) |-> res_r.busy_res)
    else $error("pulse request while not busy");

  // A processed step always leaves a result beat behind.
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_full_r)
    else $error("step processed without a result beat");

  // The input register only stalls while the result register is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_full_r && out_stall))
    else $error("input stalled with a free result register");

endmodule

`default_nettype wire

// File: bench/fan_light_relay_sequencer_tb.sv
// Self-checking testbench for the fan and light relay sequencer.
`timescale 1ns / 1ps

// One controller step as driven on the in_ channel.
typedef struct packed {
  logic       cmd_write;
  logic [2:0] cmd;
  logic       ms_tick;
  logic       fan_on_busy;
  logic       fan_off_busy;
  logic       light_on_busy;
  logic       light_off_busy;
  logic       light_relay_on;
} step_t;

typedef enum logic [3:0] {
  ST_IDLE, ST_FAN_ON, ST_FAN_ON_WAIT, ST_FAN_OFF, ST_FAN_OFF_WAIT,
  ST_SEL_WHITE, ST_SEL_VYV, ST_PULSE_ON, ST_PULSE_OFF, ST_PULSE_WAIT,
  ST_LOFF, ST_LOFF_WAIT, ST_LOFF_DONE
} seq_state_e;

class relay_seq_scoreboard;
  logic [15:0] white_ms;
  logic [15:0] vyv_ms;
  logic [23:0] timeout_ms;

  seq_state_e  state;
  logic [2:0]  held_cmd;
  logic        busy;
  logic [1:0]  mode_cur;
  logic [1:0]  mode_nxt;
  logic        toggle_goal;
  logic [1:0]  toggle_cnt;
  logic        use_vyv_delay;
  logic [15:0] pulse_ms;
  logic [23:0] off_ms;

  flrs_pkg::result_t expected_q[$];
  int          errors;
  int          n_checked;
  int          n_started;
  int          n_fan_pulses;
  int          n_light_pulses;

  function new();
    white_ms = flrs_pkg::WHITE_PULSE_RST;
    vyv_ms = flrs_pkg::VYV_PULSE_RST;
    timeout_ms = flrs_pkg::VYV_TIMEOUT_RST;
    state = ST_IDLE;
    held_cmd = flrs_pkg::CMD_NONE;
    busy = 1'b0;
    mode_cur = flrs_pkg::MODE_VYV;
    mode_nxt = flrs_pkg::MODE_OFF;
    toggle_goal = 1'b0;
    toggle_cnt = 2'd0;
    use_vyv_delay = 1'b0;
    pulse_ms = 16'd0;
    off_ms = 24'd0;
    errors = 0;
    n_checked = 0;
    n_started = 0;
    n_fan_pulses = 0;
    n_light_pulses = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [23:0] val);
    case (idx)
      flrs_pkg::REG_WHITE_PULSE: white_ms = val[15:0];
      flrs_pkg::REG_VYV_PULSE:   vyv_ms = val[15:0];
      flrs_pkg::REG_VYV_TIMEOUT: timeout_ms = val;
      default: ;
    endcase
  endfunction

  function int outstanding();
    return expected_q.size();
  endfunction

  // A held command starts only from a ready machine; codes without an action stay held.
  function void try_start();
    seq_state_e nxt;
    if (busy) return;
    case (held_cmd)
      flrs_pkg::CMD_FAN_ON:    nxt = ST_FAN_ON;
      flrs_pkg::CMD_FAN_OFF:   nxt = ST_FAN_OFF;
      flrs_pkg::CMD_WHITE_ON:  nxt = ST_SEL_WHITE;
      flrs_pkg::CMD_WHITE_OFF: nxt = ST_LOFF;
      flrs_pkg::CMD_VYV_ON:    nxt = ST_SEL_VYV;
      flrs_pkg::CMD_VYV_OFF:   nxt = ST_LOFF;
      default: return;
    endcase
    state = nxt;
    busy = 1'b1;
    held_cmd = flrs_pkg::CMD_NONE;
    n_started++;
  endfunction

  function void choose_mode(logic want_vyv);
    use_vyv_delay = want_vyv;
    toggle_cnt = 2'd0;
    if (mode_cur == flrs_pkg::MODE_WHITE) begin
      toggle_goal = !want_vyv;
      state = ST_PULSE_OFF;
    end else if (mode_cur == flrs_pkg::MODE_VYV) begin
      toggle_goal = want_vyv;
      state = ST_PULSE_OFF;
    end else begin
      // With the lights off, the remembered mode decides how many toggles are needed.
      if (mode_nxt == flrs_pkg::MODE_VYV) toggle_goal = !want_vyv;
      else if (mode_nxt == flrs_pkg::MODE_WHITE) toggle_goal = want_vyv;
      state = ST_PULSE_ON;
    end
    mode_cur = want_vyv ? flrs_pkg::MODE_VYV : flrs_pkg::MODE_WHITE;
    mode_nxt = flrs_pkg::MODE_OFF;
  endfunction

  function void note_step(step_t s);
    flrs_pkg::result_t r;
    logic [15:0] limit;
    r = '0;
    if (s.cmd_write) held_cmd = s.cmd;
    if (s.ms_tick) begin
      if (pulse_ms != 16'hFFFF) pulse_ms++;
      if (off_ms != 24'hFFFFFF) off_ms++;
    end
    case (state)
      ST_IDLE: try_start();
      ST_FAN_ON: begin
        r.fan_on_req = 1'b1;
        state = ST_FAN_ON_WAIT;
      end
      ST_FAN_ON_WAIT: begin
        if (!s.fan_on_busy) begin
          busy = 1'b0;
          state = ST_IDLE;
        end
      end
      ST_FAN_OFF: begin
        r.fan_off_req = 1'b1;
        state = ST_FAN_OFF_WAIT;
      end
      ST_FAN_OFF_WAIT: begin
        if (!s.fan_off_busy) begin
          busy = 1'b0;
          state = ST_IDLE;
        end
      end
      ST_SEL_WHITE: choose_mode(1'b0);
      ST_SEL_VYV:   choose_mode(1'b1);
      ST_PULSE_ON: begin
        r.light_on_req = 1'b1;
        pulse_ms = 16'd0;
        state = ST_PULSE_WAIT;
      end
      ST_PULSE_OFF: begin
        r.light_off_req = 1'b1;
        pulse_ms = 16'd0;
        state = ST_PULSE_WAIT;
      end
      ST_PULSE_WAIT: begin
        limit = use_vyv_delay ? vyv_ms : white_ms;
        if (pulse_ms >= limit) begin
          if (s.light_relay_on) begin
            if (!s.light_on_busy) begin
              if (toggle_cnt >= {1'b0, toggle_goal}) begin
                busy = 1'b0;
                state = ST_IDLE;
              end else begin
                state = ST_PULSE_OFF;
              end
              toggle_cnt = toggle_cnt + 2'd1;
            end
          end else if (!s.light_off_busy) begin
            state = ST_PULSE_ON;
          end
        end
      end
      ST_LOFF: begin
        r.light_off_req = 1'b1;
        state = ST_LOFF_WAIT;
      end
      ST_LOFF_WAIT: begin
        if (!s.light_off_busy) begin
          off_ms = 24'd0;
          busy = 1'b0;
          state = ST_LOFF_DONE;
        end
      end
      ST_LOFF_DONE: begin
        if (mode_cur == flrs_pkg::MODE_VYV) begin
          mode_cur = flrs_pkg::MODE_OFF;
          mode_nxt = flrs_pkg::MODE_WHITE;
          busy = 1'b0;
          state = ST_IDLE;
        end else if (mode_cur == flrs_pkg::MODE_WHITE) begin
          mode_cur = flrs_pkg::MODE_OFF;
          mode_nxt = flrs_pkg::MODE_VYV;
          busy = 1'b0;
        end else begin
          try_start();
          if (mode_nxt == flrs_pkg::MODE_VYV) begin
            if (off_ms >= timeout_ms && !busy) begin
              mode_cur = flrs_pkg::MODE_OFF;
              mode_nxt = flrs_pkg::MODE_WHITE;
              state = ST_IDLE;
            end
          end else begin
            // VYV not remembered: a command taken here is lost.
            busy = 1'b0;
            state = ST_IDLE;
          end
        end
      end
      default: state = ST_IDLE;
    endcase
    r.busy_res = busy;
    r.light_mode = mode_cur;
    r.mode_memory = mode_nxt;
    expected_q.push_back(r);
  endfunction

  function void cmp_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      if (errors <= 40)
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  function void check_result(flrs_pkg::result_t got);
    flrs_pkg::result_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 40) $display("%0t: result beat with nothing expected: %h", $time, got);
      return;
    end
    want = expected_q.pop_front();
    n_checked++;
    if (got.fan_on_req) n_fan_pulses++;
    if (got.fan_off_req) n_fan_pulses++;
    if (got.light_on_req) n_light_pulses++;
    if (got.light_off_req) n_light_pulses++;
    cmp_field("fan_on_req", int'(want.fan_on_req), int'(got.fan_on_req));
    cmp_field("fan_off_req", int'(want.fan_off_req), int'(got.fan_off_req));
    cmp_field("light_on_req", int'(want.light_on_req), int'(got.light_on_req));
    cmp_field("light_off_req", int'(want.light_off_req), int'(got.light_off_req));
    cmp_field("busy_res", int'(want.busy_res), int'(got.busy_res));
    cmp_field("light_mode", int'(want.light_mode), int'(got.light_mode));
    cmp_field("mode_memory", int'(want.mode_memory), int'(got.mode_memory));
  endfunction
endclass

module fan_light_relay_sequencer_tb;
  localparam int QUIET_LIMIT = 2000;
  localparam int N_PHASES = 7;
  // Command code with no action.
  localparam logic [2:0] CMD_SPARE = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  step_t       cur_step = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr = flrs_pkg::REG_WHITE_PULSE;
  logic [23:0] cfg_data = 24'd0;
  flrs_pkg::result_t got;

  logic        out_fan_on_req, out_fan_off_req, out_light_on_req, out_light_off_req;
  logic        out_busy_res;
  logic [1:0]  out_light_mode, out_mode_memory;

  relay_seq_scoreboard sb = new;

  bit gaps_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;
  int n_sent = 0;

  // Register settings per random phase, extremes included.
  int unsigned set_white [N_PHASES] = '{500, 0, 3, 65535, 1, 0, 2};
  int unsigned set_vyv   [N_PHASES] = '{500, 0, 1, 65535, 6, 65535, 2};
  int unsigned set_tmo   [N_PHASES] = '{2000, 0, 12, 16777215, 40, 1, 25};
  int          set_items [N_PHASES] = '{60, 130, 150, 40, 150, 60, 230};
  int          set_tick  [N_PHASES] = '{95, 50, 70, 90, 80, 60, 75};
  bit          set_gaps  [N_PHASES] = '{1, 1, 1, 0, 1, 1, 1};

  assign got = {out_fan_on_req, out_fan_off_req, out_light_on_req, out_light_off_req,
                out_busy_res, out_light_mode, out_mode_memory};

  fan_light_relay_sequencer u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd_write        (cur_step.cmd_write),
    .in_cmd              (cur_step.cmd),
    .in_ms_tick          (cur_step.ms_tick),
    .in_fan_on_busy      (cur_step.fan_on_busy),
    .in_fan_off_busy     (cur_step.fan_off_busy),
    .in_light_on_busy    (cur_step.light_on_busy),
    .in_light_off_busy   (cur_step.light_off_busy),
    .in_light_relay_on   (cur_step.light_relay_on),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_fan_on_req      (out_fan_on_req),
    .out_fan_off_req     (out_fan_off_req),
    .out_light_on_req    (out_light_on_req),
    .out_light_off_req   (out_light_off_req),
    .out_busy_res        (out_busy_res),
    .out_light_mode      (out_light_mode),
    .out_mode_memory     (out_mode_memory),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_addr            (cfg_addr),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic step_t rand_step(int tick_pct);
    step_t s;
    s.cmd_write = ($urandom_range(0, 99) < 25);
    if ($urandom_range(0, 99) < 85)
      s.cmd = 3'($urandom_range(flrs_pkg::CMD_FAN_ON, flrs_pkg::CMD_VYV_OFF));
    else s.cmd = $urandom_range(0, 1) ? CMD_SPARE : flrs_pkg::CMD_NONE;
    s.ms_tick = ($urandom_range(0, 99) < tick_pct);
    s.fan_on_busy = ($urandom_range(0, 99) < 25);
    s.fan_off_busy = ($urandom_range(0, 99) < 25);
    s.light_on_busy = ($urandom_range(0, 99) < 25);
    s.light_off_busy = ($urandom_range(0, 99) < 25);
    s.light_relay_on = 1'($urandom_range(0, 1));
    return s;
  endfunction

  function automatic step_t mk_step(int wr, logic [2:0] c, int tick, int fon_b,
                                    int foff_b, int lon_b, int loff_b, int relay);
    return {1'(wr), c, 1'(tick), 1'(fon_b), 1'(foff_b), 1'(lon_b), 1'(loff_b),
            1'(relay)};
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if (gaps_on && $urandom_range(0, 99) < 12) stall_left = pick_gap();
    end
  end

  // Sampling happens before the block's own updates at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_step(cur_step);
        n_sent++;
      end
      if (out_valid && !out_stall) sb.check_result(got);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("** fan_light_relay_sequencer: FAILED **");
    $finish;
  end

  task automatic idle_in(input int n);
    @(negedge clk);
    in_valid = 1'b0;
    cur_step = 10'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_step(input step_t s);
    if (gaps_on && $urandom_range(0, 99) < 20) idle_in(pick_gap());
    @(negedge clk);
    in_valid = 1'b1;
    cur_step = s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    step_t dir_q[$];
    logic [7:0] junk;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening at the reset register values.
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_step(1, CMD_SPARE, 1, 1, 1, 1, 1, 1));
    dir_q.push_back(mk_step(1, flrs_pkg::CMD_NONE, 0, 1, 1, 1, 1, 0));
    dir_q.push_back(mk_step(1, flrs_pkg::CMD_FAN_ON, 1, 1, 0, 0, 0, 0));
    // A fan off arriving while the fan on sequence is still running is held.
    dir_q.push_back(mk_step(1, flrs_pkg::CMD_FAN_OFF, 0, 1, 0, 0, 0, 0));
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 1, 1, 0, 0, 0, 0));
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 0, 0, 1, 0, 0, 0));
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 0, 0, 1, 0, 0, 0));
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 1, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_step(1, flrs_pkg::CMD_WHITE_OFF, 0, 0, 0, 0, 1, 1));
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 1, 0, 0, 0, 1, 1));
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 0, 0, 0, 0, 1, 0));
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 1, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_step(1, flrs_pkg::CMD_VYV_OFF, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 0, 0, 0, 0, 0, 0));
    // Lights already off with white remembered: this fan on is swallowed.
    dir_q.push_back(mk_step(1, flrs_pkg::CMD_FAN_ON, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 1, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_step(1, flrs_pkg::CMD_WHITE_ON, 0, 0, 0, 0, 0, 1));
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 1, 0, 0, 0, 0, 1));
    dir_q.push_back(mk_step(0, flrs_pkg::CMD_NONE, 1, 0, 0, 0, 0, 1));
    dir_q.push_back(mk_step(1, flrs_pkg::CMD_VYV_ON, 1, 0, 0, 0, 0, 1));
    foreach (dir_q[i]) send_step(dir_q[i]);
    wait_drain();

    for (int p = 0; p < N_PHASES; p++) begin
      junk = 8'($urandom);
      // Upper data bits of the 16-bit registers carry junk that must be dropped.
      write_reg(flrs_pkg::REG_WHITE_PULSE, {junk, set_white[p][15:0]});
      junk = 8'($urandom);
      write_reg(flrs_pkg::REG_VYV_PULSE, {junk, set_vyv[p][15:0]});
      write_reg(flrs_pkg::REG_VYV_TIMEOUT, set_tmo[p][23:0]);
      gaps_on = set_gaps[p];
      for (int k = 0; k < set_items[p]; k++) begin
        send_step(rand_step(set_tick[p]));
        if ($urandom_range(0, 99) < 2) wait_drain();
      end
      wait_drain();
    end

    gaps_on = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d steps under %0d register settings; %0d result beats checked.",
             n_sent, N_PHASES + 1, sb.n_checked);
    $display("Commands started: %0d; fan pulse requests: %0d; light pulse requests: %0d.",
             sb.n_started, sb.n_fan_pulses, sb.n_light_pulses);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("** fan_light_relay_sequencer: PASSED **");
    end else begin
      $display("** fan_light_relay_sequencer: FAILED **");
    end
    $finish;
  end
endmodule
